@@ hw/rtl/rlecr_pkg.sv @@
// ----------------------------------------------------------------------------
// rlecr_pkg
// Shared types, character codes and event codes of the cell run decoder.
// ----------------------------------------------------------------------------
package rlecr_pkg;

	// Field widths
	localparam int BYTE_W   = 8;
	localparam int POS_W    = 13;   // internal row / column
	localparam int OPOS_W   = 12;   // row / column on the result
	localparam int CNT_W    = 14;   // pending run count
	localparam int DIG_W    = 4;    // digit counter
	localparam int LEN_W    = 13;   // run length on the result
	localparam int KIND_W   = 2;
	localparam int ERR_W    = 3;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;

	localparam logic [DIG_W-1:0] MAX_DIGITS = 4'd10;
	localparam logic [CNT_W-1:0] COUNT_MAX  = 14'd16383;

	// Configuration register reset values
	localparam logic [POS_W-1:0] WIDTH_RST  = 13'd20;
	localparam logic [POS_W-1:0] HEIGHT_RST = 13'd10;

	// Register indexes (taken from paddr[2])
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Pattern characters
	localparam logic [BYTE_W-1:0] CH_DEAD   = 8'h62;  // 'b'
	localparam logic [BYTE_W-1:0] CH_LIVE   = 8'h6F;  // 'o'
	localparam logic [BYTE_W-1:0] CH_ROW    = 8'h24;  // '$'
	localparam logic [BYTE_W-1:0] CH_END    = 8'h21;  // '!'
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;  // '0'
	localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;  // '9'
	localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;

	typedef enum logic [1:0] {
		PH_RUN  = 2'd0,
		PH_DONE = 2'd1,
		PH_FAIL = 2'd2
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		EV_RUN    = 2'd0,
		EV_FINISH = 2'd1,
		EV_ERROR  = 2'd2
	} event_kind_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE      = 3'd0,
		ERR_DIGITS    = 3'd1,
		ERR_ZERO      = 3'd2,
		ERR_WIDE      = 3'd3,
		ERR_ROWS      = 3'd4
	} error_code_t;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic [CNT_W-1:0] count;
		logic [DIG_W-1:0] digits;
		phase_t           phase;
	} dec_state_t;

	typedef struct packed {
		event_kind_t       event_kind;
		logic [OPOS_W-1:0] row_index;
		logic [OPOS_W-1:0] start_column;
		logic [LEN_W-1:0]  run_length;
		logic              cell_value;
		error_code_t       error_code;
	} dec_result_t;

	typedef struct packed {
		logic [POS_W-1:0] field_width;
		logic [POS_W-1:0] field_height;
	} dec_cfg_t;

endpackage

@@ hw/rtl/rlecr_chan_if.sv @@
// ----------------------------------------------------------------------------
// rlecr_chan_if
// Valid/ready channels of the decoder: pattern bytes in, run, finish and error events out.
// ----------------------------------------------------------------------------
interface rlecr_in_if import rlecr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              restart;

	modport source (output valid, data_byte, restart, input ready);
	modport sink   (input valid, data_byte, restart, output ready);
endinterface

interface rlecr_out_if import rlecr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] event_kind;
	logic [OPOS_W-1:0] row_index;
	logic [OPOS_W-1:0] start_column;
	logic [LEN_W-1:0]  run_length;
	logic              cell_value;
	logic [ERR_W-1:0]  error_code;

	modport source (output valid, event_kind, row_index, start_column, run_length,
		cell_value, error_code, input ready);
	modport sink   (input valid, event_kind, row_index, start_column, run_length,
		cell_value, error_code, output ready);
endinterface

@@ hw/rtl/rlecr_cfg.sv @@
// ----------------------------------------------------------------------------
// rlecr_cfg
// APB register file holding the target field width and height.
// ----------------------------------------------------------------------------
module rlecr_cfg import rlecr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output dec_cfg_t          cfg
);

	logic [POS_W-1:0] width_q;
	logic [POS_W-1:0] height_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Write the addressed register in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[POS_W-1:0];
				REG_HEIGHT: height_q <= pwdata[POS_W-1:0];
				default:    ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (paddr[2])
			REG_WIDTH:  prdata = {{(APB_DW-POS_W){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(APB_DW-POS_W){1'b0}}, height_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.field_width  = width_q;
	assign cfg.field_height = height_q;

endmodule

@@ hw/rtl/rlecr_step.sv @@
// ----------------------------------------------------------------------------
// rlecr_step
// Decode one pattern byte against the current position and count state.
// ----------------------------------------------------------------------------
module rlecr_step import rlecr_pkg::*; (
	input  dec_state_t        state_cur,
	input  dec_cfg_t          cfg,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              restart,
	output dec_state_t        state_nxt,
	output logic              res_valid,
	output dec_result_t       res
);

	dec_state_t       st;
	logic             is_digit;
	logic             is_run;
	logic             is_row_end;
	logic [17:0]      count_x10;
	logic [CNT_W-1:0] run_len;
	logic [CNT_W-1:0] adv;
	logic [POS_W+1:0] run_end;
	logic [POS_W+1:0] row_next;
	logic             count_given;

	// Restart clears position, count and phase ahead of the byte
	always_comb begin
		if (restart) begin
			st.row    = '0;
			st.col    = '0;
			st.count  = '0;
			st.digits = '0;
			st.phase  = PH_RUN;
		end else begin
			st = state_cur;
		end
	end

	assign is_digit    = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign is_run      = (data_byte == CH_DEAD) || (data_byte == CH_LIVE);
	assign is_row_end  = (data_byte == CH_ROW) || (data_byte == CH_END) ||
		(data_byte == CH_NUL);
	assign count_given = (st.digits != '0);

	// count*10 + digit, as (count<<3) + (count<<1) + digit
	assign count_x10 = {1'b0, st.count, 3'b000} + {3'b000, st.count, 1'b0} +
		{14'd0, data_byte[3:0]};

	assign run_len  = count_given ? st.count : 14'd1;
	assign run_end  = {2'b00, st.col} + {1'b0, run_len};
	assign adv      = (data_byte == CH_ROW && count_given) ? st.count : 14'd1;
	assign row_next = {2'b00, st.row} + {1'b0, adv};

	always_comb begin
		state_nxt = st;
		res_valid = 1'b0;
		res       = '0;
		res.event_kind   = EV_ERROR;
		res.row_index    = st.row[OPOS_W-1:0];
		res.start_column = st.col[OPOS_W-1:0];
		res.error_code   = ERR_NONE;

		if (st.phase == PH_RUN) begin
			if (is_digit) begin
				// Accumulate a digit, saturating the count
				if (st.digits >= MAX_DIGITS) begin
					state_nxt.phase = PH_FAIL;
					res_valid       = 1'b1;
					res.error_code  = ERR_DIGITS;
				end else begin
					state_nxt.digits = st.digits + 4'd1;
					state_nxt.count  = (count_x10 > {4'd0, COUNT_MAX}) ?
						COUNT_MAX : count_x10[CNT_W-1:0];
				end
			end else if (is_run) begin
				// Emit a run and advance the column
				if (run_len == '0) begin
					state_nxt.phase = PH_FAIL;
					res_valid       = 1'b1;
					res.error_code  = ERR_ZERO;
				end else if (run_end > {2'b00, cfg.field_width}) begin
					state_nxt.phase = PH_FAIL;
					res_valid       = 1'b1;
					res.error_code  = ERR_WIDE;
				end else begin
					res_valid        = 1'b1;
					res.event_kind   = EV_RUN;
					res.run_length   = run_len[LEN_W-1:0];
					res.cell_value   = (data_byte == CH_LIVE);
					state_nxt.col    = run_end[POS_W-1:0];
					state_nxt.count  = '0;
					state_nxt.digits = '0;
				end
			end else if (is_row_end) begin
				// End one or more rows; '!' also finishes the pattern
				if (data_byte == CH_ROW && count_given && st.count == '0) begin
					state_nxt.phase = PH_FAIL;
					res_valid       = 1'b1;
					res.error_code  = ERR_ZERO;
				end else if (row_next > {2'b00, cfg.field_height}) begin
					state_nxt.phase = PH_FAIL;
					res_valid       = 1'b1;
					res.error_code  = ERR_ROWS;
				end else begin
					state_nxt.row    = row_next[POS_W-1:0];
					state_nxt.col    = '0;
					state_nxt.count  = '0;
					state_nxt.digits = '0;
					if (data_byte == CH_END) begin
						state_nxt.phase  = PH_DONE;
						res_valid        = 1'b1;
						res.event_kind   = EV_FINISH;
						res.row_index    = row_next[OPOS_W-1:0];
						res.start_column = '0;
					end
				end
			end
		end
	end

endmodule

@@ hw/rtl/rle_cell_run_decoder.sv @@
// ----------------------------------------------------------------------------
// rle_cell_run_decoder
// Run-length encoded cell pattern decoder: bytes in, run, finish and error events out.
// ----------------------------------------------------------------------------
// One pattern byte is taken per clock cycle, sustained, as long as the result
// side keeps up. A byte's event passes from the input register, where the
// step logic works it out while the byte is held, into the result register,
// from which it can be taken downstream; a stall on the result side holds it
// in the input register. The rate is set by the combinational update of row,
// column and count state between the two registers. Bytes that produce no
// event (digits, ignored characters, plain row ends, anything after a finish
// or error) give no output transaction. After a finish or an error the
// decoder stays silent until a byte arrives with restart set. Field width and
// height are written over APB at addresses 0 and 4; the user must write them
// only while the decoder is idle, which the block itself does not enforce;
// there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module rle_cell_run_decoder import rlecr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	rlecr_in_if.sink          item_in,
	rlecr_out_if.source       item_out
);

	dec_cfg_t          cfg;
	dec_state_t        state_q;
	dec_state_t        state_nxt;
	dec_result_t       res;
	dec_result_t       res_q;
	logic              res_valid;
	logic              out_valid_q;
	logic              out_free;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              restart_s1;
	logic              fire_s1;
	logic              in_fire;

	rlecr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rlecr_step u_step (
		.state_cur (state_q),
		.cfg       (cfg),
		.data_byte (byte_s1),
		.restart   (restart_s1),
		.state_nxt (state_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	// Handshake: the result register is free when empty or being drained
	assign out_free      = !out_valid_q || item_out.ready;
	assign fire_s1       = valid_s1 && out_free;
	assign item_in.ready = !valid_s1 || out_free;
	assign in_fire       = item_in.valid && item_in.ready;

	// Input register control and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1) begin
				state_q <= state_nxt;
			end
			if (out_free) begin
				out_valid_q <= fire_s1 && res_valid;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1    <= item_in.data_byte;
			restart_s1 <= item_in.restart;
		end
		if (fire_s1 && res_valid) begin
			res_q <= res;
		end
	end

	assign item_out.valid        = out_valid_q;
	assign item_out.event_kind   = res_q.event_kind;
	assign item_out.row_index    = res_q.row_index;
	assign item_out.start_column = res_q.start_column;
	assign item_out.run_length   = res_q.run_length;
	assign item_out.cell_value   = res_q.cell_value;
	assign item_out.error_code   = res_q.error_code;

	// Digit counter never passes its limit
	a_digit_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.digits <= MAX_DIGITS)
		else $error("digit counter beyond limit");

	// A stopped decoder without restart produces no transaction
	a_silent_stop: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && !restart_s1 && state_q.phase != PH_RUN |=> !out_valid_q)
		else $error("result from stopped decoder");

	// Run transactions carry a non-zero length and no error code
	a_run_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.event_kind == EV_RUN |->
		res_q.run_length != '0 && res_q.error_code == ERR_NONE)
		else $error("malformed run transaction");

	// An error transaction leaves the decoder in the failed phase
	a_error_fail: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && res_valid && res.event_kind == EV_ERROR |=>
		state_q.phase == PH_FAIL && out_valid_q && res_q.error_code != ERR_NONE)
		else $error("error without failed phase");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the cell run decoder. Pattern bytes are driven on the input
// channel, and a predictor of the decoder works out the run, finish and error
// events that each byte should raise. Events on the output channel are matched
// in order, field by field, against what the predictor queued. Directed
// sequences come first, then random patterns, broken patterns and noise under
// several field sizes, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import rlecr_pkg::*;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int SETTLE_CYCLES = 4;
	localparam int MAX_GAP       = 13;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	rlecr_in_if  in_ch ();
	rlecr_out_if out_ch ();

	rle_cell_run_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.item_in  (in_ch),
		.item_out (out_ch)
	);

	// Decoder state as predicted
	logic [POS_W-1:0] cfg_width  = WIDTH_RST;
	logic [POS_W-1:0] cfg_height = HEIGHT_RST;
	logic [POS_W-1:0] cur_row    = '0;
	logic [POS_W-1:0] cur_col    = '0;
	logic [CNT_W-1:0] run_count  = '0;
	logic [DIG_W-1:0] n_digits   = '0;
	phase_t           phase      = PH_RUN;

	dec_result_t due_events[$];

	bit restart_next = 1'b0;
	bit in_idle      = 1'b1;
	bit out_idle     = 1'b1;
	int bytes_sent   = 0;
	int bytes_acted  = 0;
	int events_seen  = 0;
	int settings     = 1;
	int n_fail       = 0;
	int cycle_count  = 0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d events outstanding", $time, due_events.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic dec_result_t make_event(event_kind_t kind, logic [POS_W-1:0] row,
			logic [POS_W-1:0] col, logic [LEN_W-1:0] len, logic val, error_code_t code);
		dec_result_t ev;
		ev.event_kind   = kind;
		ev.row_index    = row[OPOS_W-1:0];
		ev.start_column = col[OPOS_W-1:0];
		ev.run_length   = len;
		ev.cell_value   = val;
		ev.error_code   = code;
		return ev;
	endfunction

	function automatic void raise_error(error_code_t code);
		phase = PH_FAIL;
		due_events.push_back(make_event(EV_ERROR, cur_row, cur_col, '0, 1'b0, code));
	endfunction

	// Advance the predicted decoder by one byte; return 1 if the byte was acted on
	function automatic bit decode_char(logic [BYTE_W-1:0] ch, logic rs);
		int unsigned nxt;
		int unsigned len;
		if (rs) begin
			cur_row   = '0;
			cur_col   = '0;
			run_count = '0;
			n_digits  = '0;
			phase     = PH_RUN;
		end
		if (phase != PH_RUN)
			return 1'b0;

		// Digit: extend the count, saturating
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			if (n_digits >= MAX_DIGITS) begin
				raise_error(ERR_DIGITS);
			end else begin
				n_digits  = n_digits + 1'b1;
				nxt       = run_count * 10 + (ch - CH_ZERO);
				run_count = (nxt > COUNT_MAX) ? COUNT_MAX : nxt[CNT_W-1:0];
			end
			return 1'b1;
		end

		// Run of dead or live cells
		if (ch == CH_DEAD || ch == CH_LIVE) begin
			len = (n_digits == 0) ? 1 : run_count;
			if (len == 0) begin
				raise_error(ERR_ZERO);
			end else if (cur_col + len > cfg_width) begin
				raise_error(ERR_WIDE);
			end else begin
				due_events.push_back(make_event(EV_RUN, cur_row, cur_col, len[LEN_W-1:0],
					ch == CH_LIVE, ERR_NONE));
				cur_col   = cur_col + len[POS_W-1:0];
				run_count = '0;
				n_digits  = '0;
			end
			return 1'b1;
		end

		// Row end, pattern end; only a row end takes a row skip count
		if (ch == CH_ROW || ch == CH_END || ch == CH_NUL) begin
			len = (ch == CH_ROW && n_digits != 0) ? run_count : 1;
			if (len == 0) begin
				raise_error(ERR_ZERO);
			end else if (cur_row + len > cfg_height) begin
				raise_error(ERR_ROWS);
			end else begin
				cur_row   = cur_row + len[POS_W-1:0];
				cur_col   = '0;
				run_count = '0;
				n_digits  = '0;
				if (ch == CH_END) begin
					phase = PH_DONE;
					due_events.push_back(make_event(EV_FINISH, cur_row, '0, '0, 1'b0, ERR_NONE));
				end
			end
			return 1'b1;
		end

		// Anything else is ignored and keeps the count
		return 1'b0;
	endfunction

	// Drive one byte and hold it until the decoder takes it
	task automatic send_byte(input logic [BYTE_W-1:0] ch);
		int gap;
		logic rs;
		rs = restart_next;
		restart_next = 1'b0;
		gap = in_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.data_byte <= ch;
		in_ch.restart   <= rs;
		do @(posedge clk); while (!in_ch.ready);
		bytes_sent++;
		if (decode_char(ch, rs))
			bytes_acted++;
	endtask

	task automatic send_text(input string s, input bit fresh);
		int i;
		restart_next = fresh;
		for (i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_count(input int unsigned n);
		send_text($sformatf("%0d", n), 1'b0);
	endtask

	// Hold the input until every expected event is out and the pipeline is empty
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (due_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready
	task automatic write_reg(input logic idx, input logic [POS_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {{(APB_DW-POS_W){1'b0}}, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_WIDTH)
			cfg_width = val;
		else
			cfg_height = val;
	endtask

	task automatic set_field(input logic [POS_W-1:0] w, input logic [POS_W-1:0] h);
		wait_drained();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		settings++;
	endtask

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			n_fail++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endfunction

	// Event checker: random stall, then take one transaction and match it
	initial begin
		int stall;
		dec_result_t ev;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = out_idle ? $urandom_range(0, MAX_GAP) : 0;
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			events_seen++;
			if (due_events.size() == 0) begin
				n_fail++;
				$display("%0t: unexpected event, expected none actual kind %0d row %0d col %0d",
					$time, out_ch.event_kind, out_ch.row_index, out_ch.start_column);
			end else begin
				ev = due_events.pop_front();
				check_field("event_kind",   16'(ev.event_kind),   16'(out_ch.event_kind));
				check_field("row_index",    16'(ev.row_index),    16'(out_ch.row_index));
				check_field("start_column", 16'(ev.start_column), 16'(out_ch.start_column));
				check_field("run_length",   16'(ev.run_length),   16'(out_ch.run_length));
				check_field("cell_value",   16'(ev.cell_value),   16'(out_ch.cell_value));
				check_field("error_code",   16'(ev.error_code),   16'(out_ch.error_code));
			end
		end
	end

	// Runs, ignored bytes, row skip, zero byte and finish under reset sizes
	task automatic test_run_decoding();
		send_text("3ob2", 1'b1);
		send_byte(CH_ZERO - 1'b1);
		send_byte(CH_NINE + 1'b1);
		send_byte(8'hFF);
		send_text("o$2$5", 1'b0);
		send_byte(CH_NUL);
		send_text("o7!o", 1'b0);
	endtask

	// Each error, and silence after it
	task automatic test_error_cases();
		send_text("0ob", 1'b1);
		send_text("0$", 1'b1);
		send_text("21b", 1'b1);
		send_text("11$", 1'b1);
		send_text("99999o", 1'b1);
		send_text("12345678901", 1'b1);
	endtask

	// Register values beyond the output range, and zero sizes
	task automatic test_wide_registers();
		set_field(13'd8191, 13'd8191);
		send_text("4100b5o5000$o!", 1'b1);
		set_field(13'd0, 13'd0);
		send_text("o", 1'b1);
		send_text("$", 1'b1);
		send_text("!", 1'b1);
	endtask

	// Well-formed pattern with random content, sometimes broken
	task automatic random_pattern();
		int unsigned rows;
		int unsigned room;
		int unsigned len;
		int unsigned col;
		int r;
		restart_next = 1'b1;
		rows = $urandom_range(1, 4);
		for (r = 0; r < rows; r++) begin
			col = 0;
			while (col < cfg_width && $urandom_range(0, 4) != 0) begin
				room = cfg_width - col;
				case ($urandom_range(0, 19))
					0: len = room + $urandom_range(1, 3);
					1: len = 0;
					2: len = room;
					default: len = $urandom_range(1, room > 12 ? 12 : room);
				endcase
				if (len != 1 || $urandom_range(0, 1))
					send_count(len);
				send_byte($urandom_range(0, 1) ? CH_LIVE : CH_DEAD);
				if ($urandom_range(0, 9) == 0)
					send_byte(8'h0A);
				col += len;
			end
			case ($urandom_range(0, 5))
				0: send_byte(CH_NUL);
				1: begin
					send_count($urandom_range(0, 3));
					send_byte(CH_ROW);
				end
				default: send_byte(CH_ROW);
			endcase
		end
		if ($urandom_range(0, 5) == 0)
			send_count($urandom_range(1, 9));
		send_byte(CH_END);
	endtask

	// Burst of arbitrary bytes with occasional restarts
	task automatic random_noise();
		logic [BYTE_W-1:0] marks[5];
		int n;
		int i;
		marks = '{CH_DEAD, CH_LIVE, CH_ROW, CH_END, CH_NUL};
		n = $urandom_range(1, 16);
		for (i = 0; i < n; i++) begin
			restart_next = ($urandom_range(0, 7) == 0);
			case ($urandom_range(0, 2))
				0: send_byte(8'($urandom_range(0, 255)));
				1: send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
				default: send_byte(marks[$urandom_range(0, 4)]);
			endcase
		end
	endtask

	task automatic test_random_streams();
		logic [POS_W-1:0] widths[6];
		logic [POS_W-1:0] heights[6];
		int goal;
		int s;
		widths  = '{13'd1, 13'd4096, 13'd7, 13'd3, 13'd20, 13'd20};
		heights = '{13'd1, 13'd4096, 13'd12, 13'd40, 13'd10, 13'd10};
		widths[4]  = 13'($urandom_range(2, 64));
		heights[4] = 13'($urandom_range(2, 16));
		for (s = 0; s < 6; s++) begin
			set_field(widths[s], heights[s]);
			goal = bytes_sent + 160;
			while (bytes_sent < goal) begin
				in_idle  = ($urandom_range(0, 3) != 0);
				out_idle = ($urandom_range(0, 3) != 0);
				if ($urandom_range(0, 4) == 0)
					random_noise();
				else
					random_pattern();
				// hold off now and then until the output side has caught up
				if ($urandom_range(0, 49) == 0)
					wait_drained();
			end
		end
	endtask

	// Main sequence
	initial begin
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		in_ch.valid     = 1'b0;
		in_ch.data_byte = '0;
		in_ch.restart   = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_run_decoding();
		test_error_cases();
		test_wide_registers();
		test_random_streams();
		wait_drained();

		$display("%0d bytes driven (%0d acted on) over %0d field sizes, 0 to 8191 wide/high",
			bytes_sent, bytes_acted, settings);
		$display("%0d run, finish and error events matched, %0d mismatches",
			events_seen, n_fail);
		if (n_fail == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/rlecr_pkg.sv
hw/rtl/rlecr_chan_if.sv
hw/rtl/rlecr_cfg.sv
hw/rtl/rlecr_step.sv
hw/rtl/rle_cell_run_decoder.sv
tb/tb_top.sv
